// ===== design/pidc_pkg.sv =====
package pidc_pkg;

  localparam int SMP_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 31;
  localparam int INT_W   = 32;
  localparam int SUM_W   = 34;
  localparam int DRV_W   = 32;
  localparam int MA_W    = 17;
  localparam int MB_W    = 33;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_W  = 16;
  localparam int DIVD_W  = 33;
  localparam int DIVS_W  = 16;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 2;

  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVD_W);

  localparam logic [IDX_W-1:0] REG_GAIN_P    = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 2'd2;
  localparam logic [IDX_W-1:0] REG_INT_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MI,
    S_CLAMP,
    S_MP,
    S_MIN,
    S_WDIV,
    S_MD,
    S_SUM
  } pidc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/pidc_mul.sv =====
module pidc_mul
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   op_a,
  input  logic signed [MB_W-1:0]   op_b,
  output logic        [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  always_comb begin
    prod_nxt = PROD_W'($signed(op_a) * $signed(op_b));
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== design/pidc_div.sv =====
module pidc_div
  import pidc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output div_stat_t         stat
);

  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvsr_r, dvsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   trial_sub;
  logic              fits;

  always_comb begin
    trial     = {rem_r, q_r[DIVD_W-1]};
    trial_sub = trial - {1'b0, dvsr_r};
    fits      = (trial >= {1'b0, dvsr_r});
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvsr_nxt  = dvsr_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
      cnt_nxt  = DIV_STEPS;
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      q_nxt   = {q_r[DIVD_W-2:0], fits};
      rem_nxt = fits ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

// ===== design/pid_controller_integral_clamp_top.sv =====
// PID controller with a clamped integral, fixed point.
// Input stream: one request per control step carrying measured value,
// setpoint and step time. Output stream: one result per request with the
// saturated drive in tdata and the saturation flag in tuser.
// Configuration: gains and the integral bound are written through cfg_wr_en,
// cfg_index and cfg_data, one register per cycle. The user must write them
// only while no request is open; the block itself does not enforce this.
// The 33-step radix-2 divider for the derivative sets the time to a result,
// except when the step time is zero and its wait is skipped; the gain
// products share one registered multiplier. in_tready rises again together
// with out_tvalid, so a new request is taken only once the last one is done.
// A stalled receiver holds the result in the output register; the next
// request is accepted and computed meanwhile and then waits in its final
// step until the output register is free.
// Reset (rst_n low, synchronous) clears the integral and the stored error,
// sets the gains to zero and the integral bound to its maximum, and drops
// out_tvalid.
module pid_controller_integral_clamp_top
  import pidc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,   // measured, setpoint, step_time
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DRV_W-1:0]    out_tdata,  // drive
  output logic                out_tuser,  // saturated
  input  logic                cfg_wr_en,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [LIM_W-1:0]    cfg_data
);

  pidc_state_t state_r, state_nxt;

  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LIM_W-1:0]  limit_r;

  logic [INT_W-1:0]  integral_r, integral_nxt;
  logic [ERR_W-1:0]  prev_err_r, prev_err_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [SMP_W-1:0]  dt_r, dt_nxt;
  logic [DRV_W-1:0]  deriv_r, deriv_nxt;
  logic              hit_r, hit_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  logic [DRV_W-1:0]  out_data_r, out_data_nxt;
  logic              out_sat_r, out_sat_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SMP_W-1:0]  meas, setp, stime;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic [PROD_W-1:0]      prod;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVD_W-1:0] quotient;
  div_stat_t         div_stat;

  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] diff_neg;
  logic [ERR_W-1:0]  diff_mag;
  logic              diff_is_neg;

  logic signed [SUM_W-1:0] sum34;
  logic signed [SUM_W-1:0] lim34;
  logic signed [SUM_W-1:0] nlim34;
  logic signed [SUM_W-1:0] clamped;

  logic signed [PROD_W-1:0] prod_sh;
  logic [ACC_W-1:0]         total;
  logic [DIVD_W-1:0]        q_neg;

  assign meas  = in_tdata[15:0];
  assign setp  = in_tdata[31:16];
  assign stime = in_tdata[47:32];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // derivative numerator magnitude
  always_comb begin
    diff         = {err_r[ERR_W-1], err_r} - {prev_err_r[ERR_W-1], prev_err_r};
    diff_is_neg  = diff[DIFF_W-1];
    diff_neg     = -diff;
    diff_mag     = diff_is_neg ? diff_neg[ERR_W-1:0] : diff[ERR_W-1:0];
    div_dividend = {diff_mag, {FRAC_W{1'b0}}};
    div_start    = (state_r == S_MI);
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MI: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = $signed({{(MB_W-ERR_W){err_r[ERR_W-1]}}, err_r});
      end
      S_CLAMP: begin
        mul_a = $signed({gain_p_r[GAIN_W-1], gain_p_r});
        mul_b = $signed({{(MB_W-ERR_W){err_r[ERR_W-1]}}, err_r});
      end
      S_MP: begin
        mul_a = $signed({gain_i_r[GAIN_W-1], gain_i_r});
        mul_b = $signed({integral_r[INT_W-1], integral_r});
      end
      default: begin
        mul_a = $signed({gain_d_r[GAIN_W-1], gain_d_r});
        mul_b = $signed({deriv_r[DRV_W-1], deriv_r});
      end
    endcase
  end

  pidc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dt_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    sum34   = $signed({{(SUM_W-INT_W){integral_r[INT_W-1]}}, integral_r})
            + $signed(prod[SUM_W-1:0]);
    lim34   = $signed({{(SUM_W-LIM_W){1'b0}}, limit_r});
    nlim34  = -lim34;
    if (sum34 <= 0) begin
      clamped = (sum34 < nlim34) ? nlim34 : sum34;
    end else begin
      clamped = (sum34 > lim34) ? lim34 : sum34;
    end
    prod_sh = $signed(prod) >>> FRAC_W;
    total   = acc_r + {prod[PROD_W-1], prod};
    q_neg   = -quotient;
  end

  always_comb begin
    state_nxt     = state_r;
    integral_nxt  = integral_r;
    prev_err_nxt  = prev_err_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    deriv_nxt     = deriv_r;
    hit_nxt       = hit_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          err_nxt   = {setp[SMP_W-1], setp} - {meas[SMP_W-1], meas};
          dt_nxt    = stime;
          state_nxt = S_MI;
        end
      end
      S_MI: begin
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        integral_nxt = clamped[INT_W-1:0];
        state_nxt    = S_MP;
      end
      S_MP: begin
        acc_nxt   = {prod[PROD_W-1], prod};
        state_nxt = S_MIN;
      end
      S_MIN: begin
        acc_nxt   = acc_r + {prod_sh[PROD_W-1], prod_sh};
        state_nxt = S_WDIV;
      end
      S_WDIV: begin
        if (dt_r == '0) begin
          deriv_nxt = '0;
          hit_nxt   = 1'b0;
          state_nxt = S_MD;
        end else if (div_stat.done) begin
          if (diff_is_neg) begin
            if (quotient > {2'b01, {(DIVD_W-2){1'b0}}}) begin
              deriv_nxt = {1'b1, {(DRV_W-1){1'b0}}};
              hit_nxt   = 1'b1;
            end else begin
              deriv_nxt = q_neg[DRV_W-1:0];
              hit_nxt   = 1'b0;
            end
          end else begin
            if (quotient[DIVD_W-1:DRV_W-1] != '0) begin
              deriv_nxt = {1'b0, {(DRV_W-1){1'b1}}};
              hit_nxt   = 1'b1;
            end else begin
              deriv_nxt = quotient[DRV_W-1:0];
              hit_nxt   = 1'b0;
            end
          end
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!out_valid_r || out_tready) begin
          if (total[ACC_W-1:DRV_W-1] == '0 || total[ACC_W-1:DRV_W-1] == '1) begin
            out_data_nxt = total[DRV_W-1:0];
            out_sat_nxt  = hit_r;
          end else begin
            out_data_nxt = total[ACC_W-1] ? {1'b1, {(DRV_W-1){1'b0}}}
                                          : {1'b0, {(DRV_W-1){1'b1}}};
            out_sat_nxt  = 1'b1;
          end
          out_valid_nxt = 1'b1;
          prev_err_nxt  = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    dt_r       <= dt_nxt;
    deriv_r    <= deriv_nxt;
    hit_r      <= hit_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integral_r  <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integral_r  <= integral_nxt;
      prev_err_r  <= prev_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      limit_r  <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_P:    gain_p_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r <= cfg_data[GAIN_W-1:0];
        REG_INT_LIMIT: limit_r  <= cfg_data;
        default:       limit_r  <= limit_r;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MI))
    else $error("accepted request did not start the sequence");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MD && dt_r != '0) |-> div_stat.done)
    else $error("derivative used before divider finished");

  a_int_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MP) |->
      ($signed({{(SUM_W-INT_W){integral_r[INT_W-1]}}, integral_r}) <= lim34 &&
       $signed({{(SUM_W-INT_W){integral_r[INT_W-1]}}, integral_r}) >= nlim34))
    else $error("integral outside its bound");

  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SUM))
    else $error("result loaded outside the final step");

endmodule

// ===== sim/pid_controller_integral_clamp_top_test.sv =====
`timescale 1ns / 100ps

module pid_controller_integral_clamp_top_test
  import pidc_pkg::*;
;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 115;
  localparam int PHASES = 6;
  localparam longint DRIVE_MAX = 64'sd2147483647;
  localparam longint DRIVE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [SMP_W-1:0]        step_time;
    logic signed [SMP_W-1:0] setpoint;
    logic signed [SMP_W-1:0] measured;
  } pid_request_t;

  typedef struct packed {
    logic [DRV_W-1:0] drive;
    logic             saturated;
  } pid_result_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [LIM_W-1:0] value;
    pid_request_t     req;
    logic             typed;
    pid_result_t      want;
  } plan_row_t;

  typedef enum {MIX_RANDOM, MIX_EXTREME, MIX_GENTLE} gain_mix_t;
  typedef enum {LIM_MAX, LIM_ZERO, LIM_TIGHT, LIM_ANY} limit_mix_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [47:0]      in_tdata = '0;   // measured, setpoint, step_time
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DRV_W-1:0] out_tdata;       // drive
  logic             out_tuser;       // saturated
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [LIM_W-1:0] cfg_data = '0;

  logic signed [GAIN_W-1:0] kp = '0;
  logic signed [GAIN_W-1:0] ki = '0;
  logic signed [GAIN_W-1:0] kd = '0;
  logic [LIM_W-1:0]         ilim = '1;
  longint                   integ = 0;
  longint                   last_err = 0;

  pid_result_t drive_due [$];
  plan_row_t   plan [$];

  int   errors = 0;
  int   accepted = 0;
  int   results = 0;
  int   sat_results = 0;
  int   zero_dt = 0;
  int   clamps = 0;
  int   burst_free = 0;
  logic quiet = 1'b0;
  int   hold_asks = 0;
  int   hold_taken = 0;
  int   hold_left = 0;
  int   run_left = 0;

  pid_controller_integral_clamp_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clip32(longint v);
    if (v > DRIVE_MAX) return DRIVE_MAX;
    if (v < DRIVE_MIN) return DRIVE_MIN;
    return v;
  endfunction

  function automatic pid_result_t next_drive(pid_request_t req);
    longint err, dt, raw, sum, rate, acc, drv;
    pid_result_t res;
    err = longint'($signed(req.setpoint)) - longint'($signed(req.measured));
    dt = longint'(req.step_time);
    raw = integ + err * dt;
    sum = raw;
    if (sum > longint'(ilim)) begin
      sum = longint'(ilim);
    end else if (sum < -longint'(ilim)) begin
      sum = -longint'(ilim);
    end
    if (sum != raw) clamps++;
    integ = sum;
    rate = 0;
    if (dt != 0) begin
      rate = ((err - last_err) * 65536) / dt;
    end else begin
      zero_dt++;
    end
    drv = clip32(rate);
    res.saturated = (drv != rate);
    rate = drv;
    acc = longint'(kp) * err + ((longint'(ki) * integ) >>> 16) + longint'(kd) * rate;
    drv = clip32(acc);
    res.saturated = res.saturated | (drv != acc);
    res.drive = DRV_W'(drv);
    last_err = err;
    return res;
  endfunction

  function automatic plan_row_t cfg_row(logic [IDX_W-1:0] idx, logic [LIM_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t req_row(int m, int s, int dt);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.req.measured = SMP_W'(m);
    r.req.setpoint = SMP_W'(s);
    r.req.step_time = SMP_W'(dt);
    return r;
  endfunction

  function automatic plan_row_t check_row(int m, int s, int dt, logic [DRV_W-1:0] drive,
                                          logic sat);
    plan_row_t r;
    r = req_row(m, s, dt);
    r.typed = 1'b1;
    r.want.drive = drive;
    r.want.saturated = sat;
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(gain_mix_t mix);
    case (mix)
      MIX_EXTREME: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      MIX_GENTLE: return GAIN_W'($urandom_range(0, 1024)) - 16'd512;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit(limit_mix_t mix);
    case (mix)
      LIM_MAX: return '1;
      LIM_ZERO: return '0;
      LIM_TIGHT: return LIM_W'($urandom_range(0, 1 << 22));
      default: return LIM_W'($urandom);
    endcase
  endfunction

  function automatic pid_request_t random_request();
    pid_request_t req;
    req.setpoint = SMP_W'($urandom);
    req.measured = SMP_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      req.measured = req.setpoint + SMP_W'($urandom_range(0, 600)) - 16'd300;
    end
    case ($urandom_range(0, 7))
      0: req.step_time = '0;
      1: req.step_time = 16'd1;
      2: req.step_time = '1;
      3, 4: req.step_time = SMP_W'($urandom_range(1, 64));
      default: req.step_time = SMP_W'($urandom);
    endcase
    return req;
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic send_request(pid_request_t req, logic typed, pid_result_t want);
    pid_result_t res;
    in_tdata <= req;
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
    end while (!in_tready);
    @(posedge clk);
    res = next_drive(req);
    drive_due.push_back(typed ? want : res);
    accepted++;
  endtask

  task automatic idle_gap();
    int n;
    n = 0;
    if (!quiet && burst_free == 0 && $urandom_range(0, 3) == 0) n = $urandom_range(1, 10);
    if (burst_free != 0) burst_free--;
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [LIM_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN_P: kp = value[GAIN_W-1:0];
      REG_GAIN_I: ki = value[GAIN_W-1:0];
      REG_GAIN_D: kd = value[GAIN_W-1:0];
      REG_INT_LIMIT: ilim = value;
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_phase(gain_mix_t gm, limit_mix_t lm);
    drain();
    cfg_write(REG_GAIN_P, {15'($urandom), pick_gain(gm)});
    cfg_write(REG_GAIN_I, {15'($urandom), pick_gain(gm)});
    cfg_write(REG_GAIN_D, {15'($urandom), pick_gain(gm)});
    cfg_write(REG_INT_LIMIT, pick_limit(lm));
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if (out_tready && $urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      run_left <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
      run_left <= $urandom_range(0, 40);
    end
  end

  always @(negedge clk) begin : check_results
    pid_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      results++;
      if (out_tuser) sat_results++;
      if (drive_due.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no request pending", results));
      end else begin
        due = drive_due.pop_front();
        if (out_tdata !== due.drive) begin
          flag_error($sformatf("result %0d drive %0d, want %0d", results,
                               $signed(out_tdata), $signed(due.drive)));
        end
        if (out_tuser !== due.saturated) begin
          flag_error($sformatf("result %0d saturated %b, want %b", results,
                               out_tuser, due.saturated));
        end
      end
    end
  end

  initial begin
    pid_result_t none;
    none = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back(check_row(0, 0, 0, 32'd0, 1'b0));
    plan.push_back(check_row(-32768, 32767, 0, 32'd0, 1'b0));
    plan.push_back(check_row(32767, -32768, 1, 32'd0, 1'b1));
    plan.push_back(check_row(0, 0, 65535, 32'd0, 1'b0));
    plan.push_back(cfg_row(REG_GAIN_P, 31'd256));
    plan.push_back(check_row(-32768, 32767, 0, 32'sd16776960, 1'b0));
    plan.push_back(check_row(32767, -32768, 0, -32'sd16776960, 1'b0));
    plan.push_back(cfg_row(REG_GAIN_P, 31'h0000_8000));
    plan.push_back(check_row(-32768, 32767, 0, -32'sd2147450880, 1'b0));
    plan.push_back(cfg_row(REG_GAIN_P, 31'h7FFF_0000));
    plan.push_back(cfg_row(REG_GAIN_D, 31'd32767));
    plan.push_back(check_row(32767, -32768, 1, 32'h8000_0000, 1'b1));
    plan.push_back(check_row(-32768, 32767, 1, 32'h7FFF_FFFF, 1'b1));
    plan.push_back(cfg_row(REG_GAIN_D, 31'd0));
    plan.push_back(cfg_row(REG_GAIN_I, 31'd32767));
    plan.push_back(cfg_row(REG_INT_LIMIT, 31'd0));
    plan.push_back(check_row(0, 100, 65535, 32'd0, 1'b0));
    plan.push_back(cfg_row(REG_INT_LIMIT, 31'h7FFF_FFFF));
    plan.push_back(req_row(-32768, 32767, 65535));
    plan.push_back(req_row(-32768, 32767, 65535));
    plan.push_back(req_row(32767, -32768, 65535));
    plan.push_back(cfg_row(REG_GAIN_P, 31'h0000_FF00));
    plan.push_back(cfg_row(REG_GAIN_I, 31'h0000_8000));
    plan.push_back(cfg_row(REG_GAIN_D, 31'h0000_8000));
    plan.push_back(cfg_row(REG_INT_LIMIT, 31'd65536));
    plan.push_back(req_row(1000, -1000, 3));
    plan.push_back(req_row(-5, 5, 0));
    plan.push_back(req_row(0, 0, 1));

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain();
        cfg_write(plan[k].idx, plan[k].value);
      end else begin
        send_request(plan[k].req, plan[k].typed, plan[k].want);
        idle_gap();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_phase(MIX_RANDOM, LIM_MAX);
        1: program_phase(MIX_EXTREME, LIM_ZERO);
        2: program_phase(MIX_RANDOM, LIM_TIGHT);
        3: program_phase(MIX_GENTLE, LIM_ANY);
        4: program_phase(MIX_EXTREME, LIM_MAX);
        default: begin
          program_phase(MIX_RANDOM, LIM_ANY);
          quiet <= 1'b1;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 20) begin
          hold_asks <= hold_asks + 1;
          burst_free = 12;
        end
        send_request(random_request(), 1'b0, none);
        idle_gap();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d control steps over %0d gain settings and the directed rows:",
             accepted, PHASES);
    $display("%0d results, %0d saturated, zero step time on %0d steps, bound reached on %0d",
             results, sat_results, zero_dt, clamps);
    if (errors == 0) begin
      $display("pid_controller_integral_clamp_top_test: clean");
    end else begin
      $display("pid_controller_integral_clamp_top_test: errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", drive_due.size());
    $display("pid_controller_integral_clamp_top_test: errors");
    $finish;
  end

endmodule
